FILE: rtl/sip_pkg.sv
// Shared constants for the segment intersection point block.
package sip_pkg;

   // Default endpoint width and fraction width of the result.
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // Result coordinates are always given as this many bits.
   localparam int OUT_BITS = 32;

endpackage

FILE: rtl/segment_intersection_point.sv
// Segment intersection point: pipelined test of two segments and their meeting point.
//
// Each input beat carries two segments A and B as signed integer endpoints.
// The result beat tells whether they meet at a single point inside the
// bounding box of both segments (edges count), and gives the point as signed
// fixed point with FRAC_BITS fraction bits, each coordinate truncated toward
// zero; coordinates read zero when nothing is found.
// A segment with equal x at both ends counts as vertical: if exactly one is
// vertical the other line is evaluated at its x. If neither is, the two
// lines are intersected. Two vertical segments, or parallel slopes
// (collinear overlap included), give no intersection.
// Rate: one beat per clock while no output beat is held, with no state carried
// between beats. The two restoring dividers retire one quotient bit per stage;
// five stages of differencing, cross products, operand select, multiply and
// sum sit ahead of them and one stage of sign fix and box test follows.
// The pipeline advances as a whole whenever the output register is empty or
// being taken, so req_stall simply mirrors a held output beat.
module segment_intersection_point #(
   parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_BITS-1:0]        req_seg_a_start_x,
   input  logic signed [COORD_BITS-1:0]        req_seg_a_start_y,
   input  logic signed [COORD_BITS-1:0]        req_seg_a_end_x,
   input  logic signed [COORD_BITS-1:0]        req_seg_a_end_y,
   input  logic signed [COORD_BITS-1:0]        req_seg_b_start_x,
   input  logic signed [COORD_BITS-1:0]        req_seg_b_start_y,
   input  logic signed [COORD_BITS-1:0]        req_seg_b_end_x,
   input  logic signed [COORD_BITS-1:0]        req_seg_b_end_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic signed [sip_pkg::OUT_BITS-1:0] rsp_cross_x,
   output logic signed [sip_pkg::OUT_BITS-1:0] rsp_cross_y
);
   import sip_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int DX   = C + 1;          // coordinate difference
   localparam int PW   = 2 * DX;         // cross product term
   localparam int DENW = PW + 1;         // denominator / tn, signed
   localparam int NW   = DX + DENW + 1;  // numerator, signed
   localparam int QB   = C + F;          // quotient magnitude bits
   localparam int HW   = NW - C;         // numerator bits above the quotient
   localparam int BW   = QB + 1;         // signed quotient and box bounds

   // Whole pipeline moves together.
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------------------------------------------------------------
   // Stage 1: differences and the common bounding box of both segments.
   // A point inside both boxes lies inside their overlap, so four bounds do.
   // ---------------------------------------------------------------------
   logic s1_vld_ff;
   logic signed [C-1:0]  s1_ax0_ff, s1_ay0_ff, s1_bx0_ff, s1_by0_ff;
   logic signed [DX-1:0] s1_dxa_ff, s1_dya_ff, s1_dxb_ff, s1_dyb_ff;
   logic signed [DX-1:0] s1_bxa_ff, s1_bya_ff;
   logic signed [C-1:0]  s1_xlo_ff, s1_xhi_ff, s1_ylo_ff, s1_yhi_ff;

   logic signed [C-1:0] axlo, axhi, aylo, ayhi, bxlo, bxhi, bylo, byhi;
   logic signed [C-1:0] s1_xlo_in, s1_xhi_in, s1_ylo_in, s1_yhi_in;

   always_comb begin
      axlo = (req_seg_a_start_x < req_seg_a_end_x) ? req_seg_a_start_x : req_seg_a_end_x;
      axhi = (req_seg_a_start_x < req_seg_a_end_x) ? req_seg_a_end_x : req_seg_a_start_x;
      aylo = (req_seg_a_start_y < req_seg_a_end_y) ? req_seg_a_start_y : req_seg_a_end_y;
      ayhi = (req_seg_a_start_y < req_seg_a_end_y) ? req_seg_a_end_y : req_seg_a_start_y;
      bxlo = (req_seg_b_start_x < req_seg_b_end_x) ? req_seg_b_start_x : req_seg_b_end_x;
      bxhi = (req_seg_b_start_x < req_seg_b_end_x) ? req_seg_b_end_x : req_seg_b_start_x;
      bylo = (req_seg_b_start_y < req_seg_b_end_y) ? req_seg_b_start_y : req_seg_b_end_y;
      byhi = (req_seg_b_start_y < req_seg_b_end_y) ? req_seg_b_end_y : req_seg_b_start_y;
      s1_xlo_in = (axlo > bxlo) ? axlo : bxlo;
      s1_xhi_in = (axhi < bxhi) ? axhi : bxhi;
      s1_ylo_in = (aylo > bylo) ? aylo : bylo;
      s1_yhi_in = (ayhi < byhi) ? ayhi : byhi;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ax0_ff <= req_seg_a_start_x;
         s1_ay0_ff <= req_seg_a_start_y;
         s1_bx0_ff <= req_seg_b_start_x;
         s1_by0_ff <= req_seg_b_start_y;
         s1_dxa_ff <= DX'(req_seg_a_end_x) - DX'(req_seg_a_start_x);
         s1_dya_ff <= DX'(req_seg_a_end_y) - DX'(req_seg_a_start_y);
         s1_dxb_ff <= DX'(req_seg_b_end_x) - DX'(req_seg_b_start_x);
         s1_dyb_ff <= DX'(req_seg_b_end_y) - DX'(req_seg_b_start_y);
         s1_bxa_ff <= DX'(req_seg_b_start_x) - DX'(req_seg_a_start_x);
         s1_bya_ff <= DX'(req_seg_b_start_y) - DX'(req_seg_a_start_y);
         s1_xlo_ff <= s1_xlo_in;
         s1_xhi_ff <= s1_xhi_in;
         s1_ylo_ff <= s1_ylo_in;
         s1_yhi_ff <= s1_yhi_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: cross products and vertical flags.
   // ---------------------------------------------------------------------
   logic s2_vld_ff, s2_va_ff, s2_vb_ff;
   logic signed [C-1:0]  s2_ax0_ff, s2_ay0_ff, s2_bx0_ff, s2_by0_ff;
   logic signed [DX-1:0] s2_dxa_ff, s2_dya_ff, s2_dxb_ff, s2_dyb_ff, s2_bxa_ff;
   logic signed [PW-1:0] s2_pd1_ff, s2_pd2_ff, s2_pt1_ff, s2_pt2_ff;
   logic signed [C-1:0]  s2_xlo_ff, s2_xhi_ff, s2_ylo_ff, s2_yhi_ff;
   logic signed [PW-1:0] s2_pd1_in, s2_pd2_in, s2_pt1_in, s2_pt2_in;

   assign s2_pd1_in = s1_dxa_ff * s1_dyb_ff;
   assign s2_pd2_in = s1_dya_ff * s1_dxb_ff;
   assign s2_pt1_in = s1_bxa_ff * s1_dyb_ff;
   assign s2_pt2_in = s1_bya_ff * s1_dxb_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_va_ff  <= (s1_dxa_ff == '0);
         s2_vb_ff  <= (s1_dxb_ff == '0);
         s2_ax0_ff <= s1_ax0_ff;
         s2_ay0_ff <= s1_ay0_ff;
         s2_bx0_ff <= s1_bx0_ff;
         s2_by0_ff <= s1_by0_ff;
         s2_dxa_ff <= s1_dxa_ff;
         s2_dya_ff <= s1_dya_ff;
         s2_dxb_ff <= s1_dxb_ff;
         s2_dyb_ff <= s1_dyb_ff;
         s2_bxa_ff <= s1_bxa_ff;
         s2_pd1_ff <= s2_pd1_in;
         s2_pd2_ff <= s2_pd2_in;
         s2_pt1_ff <= s2_pt1_in;
         s2_pt2_ff <= s2_pt2_in;
         s2_xlo_ff <= s1_xlo_ff;
         s2_xhi_ff <= s1_xhi_ff;
         s2_ylo_ff <= s1_ylo_ff;
         s2_yhi_ff <= s1_yhi_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: denominator and operand select. Every case reduces to
   // num = u1*v1 + u2*v2 for each coordinate.
   // ---------------------------------------------------------------------
   logic s3_vld_ff, s3_ok_ff;
   logic signed [DENW-1:0] s3_den_ff;
   logic signed [C-1:0]    s3_xu1_ff, s3_yu1_ff;
   logic signed [DENW-1:0] s3_xv1_ff, s3_yv1_ff, s3_xv2_ff, s3_yv2_ff;
   logic signed [DX-1:0]   s3_xu2_ff, s3_yu2_ff;
   logic signed [C-1:0]    s3_xlo_ff, s3_xhi_ff, s3_ylo_ff, s3_yhi_ff;

   logic signed [DENW-1:0] den_gen, tn_gen;
   logic                   s3_ok_in;
   logic signed [DENW-1:0] s3_den_in;
   logic signed [C-1:0]    s3_xu1_in, s3_yu1_in;
   logic signed [DENW-1:0] s3_xv1_in, s3_yv1_in, s3_xv2_in, s3_yv2_in;
   logic signed [DX-1:0]   s3_xu2_in, s3_yu2_in;

   always_comb begin
      den_gen   = DENW'(s2_pd1_ff) - DENW'(s2_pd2_ff);
      tn_gen    = DENW'(s2_pt1_ff) - DENW'(s2_pt2_ff);
      s3_ok_in  = 1'b1;
      s3_den_in = den_gen;
      s3_xu1_in = s2_ax0_ff;
      s3_xv1_in = den_gen;
      s3_xu2_in = s2_dxa_ff;
      s3_xv2_in = tn_gen;
      s3_yu1_in = s2_ay0_ff;
      s3_yv1_in = den_gen;
      s3_yu2_in = s2_dya_ff;
      s3_yv2_in = tn_gen;
      if (s2_va_ff && s2_vb_ff) begin
         s3_ok_in = 1'b0;
      end else if (s2_va_ff) begin
         // A vertical: B's line at x = ax0
         s3_den_in = DENW'(s2_dxb_ff);
         s3_xu1_in = s2_ax0_ff;
         s3_xv1_in = DENW'(s2_dxb_ff);
         s3_xu2_in = '0;
         s3_xv2_in = '0;
         s3_yu1_in = s2_by0_ff;
         s3_yv1_in = DENW'(s2_dxb_ff);
         s3_yu2_in = -s2_bxa_ff;
         s3_yv2_in = DENW'(s2_dyb_ff);
      end else if (s2_vb_ff) begin
         // B vertical: A's line at x = bx0
         s3_den_in = DENW'(s2_dxa_ff);
         s3_xu1_in = s2_bx0_ff;
         s3_xv1_in = DENW'(s2_dxa_ff);
         s3_xu2_in = '0;
         s3_xv2_in = '0;
         s3_yu1_in = s2_ay0_ff;
         s3_yv1_in = DENW'(s2_dxa_ff);
         s3_yu2_in = s2_bxa_ff;
         s3_yv2_in = DENW'(s2_dya_ff);
      end else begin
         s3_ok_in = (den_gen != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ok_ff  <= s3_ok_in;
         s3_den_ff <= s3_den_in;
         s3_xu1_ff <= s3_xu1_in;
         s3_xv1_ff <= s3_xv1_in;
         s3_xu2_ff <= s3_xu2_in;
         s3_xv2_ff <= s3_xv2_in;
         s3_yu1_ff <= s3_yu1_in;
         s3_yv1_ff <= s3_yv1_in;
         s3_yu2_ff <= s3_yu2_in;
         s3_yv2_ff <= s3_yv2_in;
         s3_xlo_ff <= s2_xlo_ff;
         s3_xhi_ff <= s2_xhi_ff;
         s3_ylo_ff <= s2_ylo_ff;
         s3_yhi_ff <= s2_yhi_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: numerator products.
   // ---------------------------------------------------------------------
   logic s4_vld_ff, s4_ok_ff;
   logic signed [DENW-1:0]    s4_den_ff;
   logic signed [C+DENW-1:0]  s4_xp1_ff, s4_yp1_ff;
   logic signed [DX+DENW-1:0] s4_xp2_ff, s4_yp2_ff;
   logic signed [C-1:0]       s4_xlo_ff, s4_xhi_ff, s4_ylo_ff, s4_yhi_ff;
   logic signed [C+DENW-1:0]  s4_xp1_in, s4_yp1_in;
   logic signed [DX+DENW-1:0] s4_xp2_in, s4_yp2_in;

   assign s4_xp1_in = s3_xu1_ff * s3_xv1_ff;
   assign s4_xp2_in = s3_xu2_ff * s3_xv2_ff;
   assign s4_yp1_in = s3_yu1_ff * s3_yv1_ff;
   assign s4_yp2_in = s3_yu2_ff * s3_yv2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ok_ff  <= s3_ok_ff;
         s4_den_ff <= s3_den_ff;
         s4_xp1_ff <= s4_xp1_in;
         s4_xp2_ff <= s4_xp2_in;
         s4_yp1_ff <= s4_yp1_in;
         s4_yp2_ff <= s4_yp2_in;
         s4_xlo_ff <= s3_xlo_ff;
         s4_xhi_ff <= s3_xhi_ff;
         s4_ylo_ff <= s3_ylo_ff;
         s4_yhi_ff <= s3_yhi_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: numerator sums.
   // ---------------------------------------------------------------------
   logic s5_vld_ff, s5_ok_ff;
   logic signed [DENW-1:0] s5_den_ff;
   logic signed [NW-1:0]   s5_xn_ff, s5_yn_ff;
   logic signed [C-1:0]    s5_xlo_ff, s5_xhi_ff, s5_ylo_ff, s5_yhi_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_ok_ff  <= s4_ok_ff;
         s5_den_ff <= s4_den_ff;
         s5_xn_ff  <= NW'(s4_xp1_ff) + NW'(s4_xp2_ff);
         s5_yn_ff  <= NW'(s4_yp1_ff) + NW'(s4_yp2_ff);
         s5_xlo_ff <= s4_xlo_ff;
         s5_xhi_ff <= s4_xhi_ff;
         s5_ylo_ff <= s4_ylo_ff;
         s5_yhi_ff <= s4_yhi_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Divider load: magnitudes, result sign, range check. A quotient of
   // 2^QB or more is far outside any box, so it only raises a flag.
   // ---------------------------------------------------------------------
   logic [DENW-1:0]   ld_m;
   logic [NW-1:0]     ld_xmag, ld_ymag;
   logic [NW+F-1:0]   ld_xd, ld_yd;
   logic [HW-1:0]     ld_xhi, ld_yhi;
   logic              ld_xovf, ld_yovf, ld_xneg, ld_yneg;

   always_comb begin
      ld_m    = s5_den_ff[DENW-1] ? DENW'(-s5_den_ff) : DENW'(s5_den_ff);
      ld_xmag = s5_xn_ff[NW-1] ? NW'(-s5_xn_ff) : NW'(s5_xn_ff);
      ld_ymag = s5_yn_ff[NW-1] ? NW'(-s5_yn_ff) : NW'(s5_yn_ff);
      ld_xd   = {ld_xmag, {F{1'b0}}};
      ld_yd   = {ld_ymag, {F{1'b0}}};
      ld_xhi  = ld_xmag[NW-1:C];
      ld_yhi  = ld_ymag[NW-1:C];
      ld_xovf = (HW'(ld_m) <= ld_xhi);
      ld_yovf = (HW'(ld_m) <= ld_yhi);
      ld_xneg = s5_xn_ff[NW-1] ^ s5_den_ff[DENW-1];
      ld_yneg = s5_yn_ff[NW-1] ^ s5_den_ff[DENW-1];
   end

   // ---------------------------------------------------------------------
   // Restoring dividers, one quotient bit per stage for x and y.
   // ---------------------------------------------------------------------
   logic                dv_vld_ff  [0:QB];
   logic                dv_ok_ff   [0:QB];
   logic                dv_xneg_ff [0:QB];
   logic                dv_yneg_ff [0:QB];
   logic [DENW-1:0]     dv_m_ff    [0:QB];
   logic [DENW-1:0]     dv_xr_ff   [0:QB];
   logic [DENW-1:0]     dv_yr_ff   [0:QB];
   logic [QB-1:0]       dv_xd_ff   [0:QB];
   logic [QB-1:0]       dv_yd_ff   [0:QB];
   logic [QB-1:0]       dv_xq_ff   [0:QB];
   logic [QB-1:0]       dv_yq_ff   [0:QB];
   logic signed [C-1:0] dv_xlo_ff  [0:QB];
   logic signed [C-1:0] dv_xhi_ff  [0:QB];
   logic signed [C-1:0] dv_ylo_ff  [0:QB];
   logic signed [C-1:0] dv_yhi_ff  [0:QB];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ok_ff[0]   <= s5_ok_ff && !ld_xovf && !ld_yovf;
         dv_xneg_ff[0] <= ld_xneg;
         dv_yneg_ff[0] <= ld_yneg;
         dv_m_ff[0]    <= ld_m;
         dv_xr_ff[0]   <= ld_xhi[DENW-1:0];
         dv_yr_ff[0]   <= ld_yhi[DENW-1:0];
         dv_xd_ff[0]   <= ld_xd[QB-1:0];
         dv_yd_ff[0]   <= ld_yd[QB-1:0];
         dv_xq_ff[0]   <= '0;
         dv_yq_ff[0]   <= '0;
         dv_xlo_ff[0]  <= s5_xlo_ff;
         dv_xhi_ff[0]  <= s5_xhi_ff;
         dv_ylo_ff[0]  <= s5_ylo_ff;
         dv_yhi_ff[0]  <= s5_yhi_ff;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_div
      logic [DENW:0]   xs, ys;
      logic            xge, yge;
      logic [DENW-1:0] xr_in, yr_in;

      always_comb begin
         xs    = {dv_xr_ff[k], dv_xd_ff[k][QB-1]};
         ys    = {dv_yr_ff[k], dv_yd_ff[k][QB-1]};
         xge   = (xs >= {1'b0, dv_m_ff[k]});
         yge   = (ys >= {1'b0, dv_m_ff[k]});
         xr_in = xge ? DENW'(xs - {1'b0, dv_m_ff[k]}) : xs[DENW-1:0];
         yr_in = yge ? DENW'(ys - {1'b0, dv_m_ff[k]}) : ys[DENW-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ok_ff[k+1]   <= dv_ok_ff[k];
            dv_xneg_ff[k+1] <= dv_xneg_ff[k];
            dv_yneg_ff[k+1] <= dv_yneg_ff[k];
            dv_m_ff[k+1]    <= dv_m_ff[k];
            dv_xr_ff[k+1]   <= xr_in;
            dv_yr_ff[k+1]   <= yr_in;
            dv_xd_ff[k+1]   <= dv_xd_ff[k] << 1;
            dv_yd_ff[k+1]   <= dv_yd_ff[k] << 1;
            dv_xq_ff[k+1]   <= {dv_xq_ff[k][QB-2:0], xge};
            dv_yq_ff[k+1]   <= {dv_yq_ff[k][QB-2:0], yge};
            dv_xlo_ff[k+1]  <= dv_xlo_ff[k];
            dv_xhi_ff[k+1]  <= dv_xhi_ff[k];
            dv_ylo_ff[k+1]  <= dv_ylo_ff[k];
            dv_yhi_ff[k+1]  <= dv_yhi_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: sign, box test, zero when not found.
   // ---------------------------------------------------------------------
   logic signed [BW-1:0] fin_qx, fin_qy, fin_xlo, fin_xhi, fin_ylo, fin_yhi;
   logic                 fin_found;
   logic                 rsp_found_ff;
   logic signed [OUT_BITS-1:0] rsp_cross_x_ff, rsp_cross_y_ff;

   always_comb begin
      fin_qx  = dv_xneg_ff[QB] ? -$signed({1'b0, dv_xq_ff[QB]}) : $signed({1'b0, dv_xq_ff[QB]});
      fin_qy  = dv_yneg_ff[QB] ? -$signed({1'b0, dv_yq_ff[QB]}) : $signed({1'b0, dv_yq_ff[QB]});
      fin_xlo = BW'($signed({dv_xlo_ff[QB], {F{1'b0}}}));
      fin_xhi = BW'($signed({dv_xhi_ff[QB], {F{1'b0}}}));
      fin_ylo = BW'($signed({dv_ylo_ff[QB], {F{1'b0}}}));
      fin_yhi = BW'($signed({dv_yhi_ff[QB], {F{1'b0}}}));
      fin_found = dv_ok_ff[QB] &&
                  (fin_qx >= fin_xlo) && (fin_qx <= fin_xhi) &&
                  (fin_qy >= fin_ylo) && (fin_qy <= fin_yhi);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_found_ff   <= fin_found;
         rsp_cross_x_ff <= fin_found ? OUT_BITS'(fin_qx) : '0;
         rsp_cross_y_ff <= fin_found ? OUT_BITS'(fin_qy) : '0;
      end
   end

   // Valid bits travel with the beats.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         s5_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= req_valid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         s5_vld_ff    <= s4_vld_ff;
         rsp_valid_ff <= dv_vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= s5_vld_ff;
      end
   end

   for (genvar v = 0; v < QB; v++) begin : g_vld
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[v+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[v+1] <= dv_vld_ff[v];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_cross_x = rsp_cross_x_ff;
   assign rsp_cross_y = rsp_cross_y_ff;

endmodule
